[rtl/core/utf8sd_pkg.sv]
package utf8sd_pkg;

   localparam int CpWidth     = 21;
   localparam int ByteWidth   = 8;
   localparam int LenWidth    = 3;
   localparam int GatherWidth = 2;
   localparam int CountWidth  = 3;
   localparam int PayloadBits = 6;

   // Most results that a single input byte can cause.
   localparam logic [CountWidth-1:0] MaxResults = 3'd4;

   localparam logic [CpWidth-1:0] ReplacementReset = 21'd65533;

   // Byte class prefixes, matched against the top bits of a byte.
   localparam logic [1:0] ContPrefix  = 2'b10;
   localparam logic [2:0] Lead2Prefix = 3'b110;
   localparam logic [3:0] Lead3Prefix = 4'b1110;
   localparam logic [4:0] Lead4Prefix = 5'b11110;

   // Sequence lengths; LenIdle means that no sequence is pending.
   localparam logic [LenWidth-1:0] LenIdle = 3'd0;
   localparam logic [LenWidth-1:0] Len2    = 3'd2;
   localparam logic [LenWidth-1:0] Len3    = 3'd3;
   localparam logic [LenWidth-1:0] Len4    = 3'd4;

   // Results of one byte: rep_count replacements, then an optional data value.
   typedef struct packed {
      logic [CountWidth-1:0] rep_count;
      logic                  has_data;
      logic [CpWidth-1:0]    data;
   } burst_type;

endpackage

[rtl/core/utf8_stream_decoder.sv]
// UTF-8 stream decoder: takes text one byte per beat on the req_ channel and
// gives code points on the rsp_ channel, each with last_of_run set on the
// final result caused by its byte. ASCII bytes pass straight through; a
// 2, 3 or 4 byte sequence yields one code point when its last byte arrives.
// Bytes that cannot be decoded (broken sequences, stray continuations, F8-FF,
// or a sequence cut off by req_end_of_text) give the replacement code point
// held in the csr_ register, which resets to U+FFFD.
// A byte accepted into the input stage is decoded as it moves on into the
// burst stage, whose first result is then shown on rsp_. A byte that only
// extends a sequence gives no result and leaves the burst stage free.
// Throughput: one byte per cycle while each byte gives at most one result
// and rsp_ready is high. A byte with more results holds the burst stage
// until its last leaves, one per beat; the input stage keeps the next byte.
// Reset clears the pending sequence and both stages, and returns the
// replacement value to U+FFFD.
// When the receiver stalls, the current result holds on rsp_, the decoded
// burst waits, and one more byte is still taken into an empty input stage
// before req_ready falls.
module utf8_stream_decoder (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [utf8sd_pkg::ByteWidth-1:0]    req_text_byte,
   input  logic                                req_end_of_text,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [utf8sd_pkg::CpWidth-1:0]      rsp_code_point,
   output logic                                rsp_last_of_run,
   input  logic                                csr_write_enable,
   input  logic [utf8sd_pkg::CpWidth-1:0]      csr_write_data
);

   // Input stage: one byte waiting for the decoder.
   logic                               in_valid_ff, in_valid_in;
   logic [utf8sd_pkg::ByteWidth-1:0]   in_byte_ff;
   logic                               in_eot_ff;
   logic [utf8sd_pkg::CpWidth-1:0]     repl_ff;

   logic                  accept;
   logic                  advance;
   logic                  burst_free;
   utf8sd_pkg::burst_type decoded;

   // The byte moves into the decoder whenever the burst stage can take its
   // results; zero-result bytes move through the same way.
   assign advance   = in_valid_ff && burst_free;
   assign req_ready = !in_valid_ff || advance;
   assign accept    = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         repl_ff     <= utf8sd_pkg::ReplacementReset;
      end else begin
         in_valid_ff <= in_valid_in;
         if (csr_write_enable) begin
            repl_ff <= csr_write_data;
         end
      end
      if (accept) begin
         in_byte_ff <= req_text_byte;
         in_eot_ff  <= req_end_of_text;
      end
   end

   // Decoder owns the pending-sequence state and updates it as a byte moves on.
   utf8sd_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .fire        (advance),
      .text_byte   (in_byte_ff),
      .end_of_text (in_eot_ff),
      .burst       (decoded)
   );

   // Burst stage hands out the replacements, then the data value, one a beat.
   utf8sd_burst u_burst (
      .clock           (clock),
      .reset           (reset),
      .load            (advance),
      .next_burst      (decoded),
      .replacement     (repl_ff),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_code_point  (rsp_code_point),
      .rsp_last_of_run (rsp_last_of_run),
      .free            (burst_free)
   );

endmodule

[rtl/core/utf8sd_decode.sv]
module utf8sd_decode (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               fire,
   input  logic [utf8sd_pkg::ByteWidth-1:0]   text_byte,
   input  logic                               end_of_text,
   output utf8sd_pkg::burst_type              burst
);

   logic [utf8sd_pkg::LenWidth-1:0]    len_ff, len_in;
   logic [utf8sd_pkg::GatherWidth-1:0] gathered_ff, gathered_in;
   logic [utf8sd_pkg::CpWidth-1:0]     partial_ff, partial_in;

   logic                               pending;
   logic                               is_cont;
   logic [utf8sd_pkg::GatherWidth-1:0] gathered_next;
   logic [utf8sd_pkg::CpWidth-1:0]     partial_shift;
   logic                               seq_done;
   logic [utf8sd_pkg::LenWidth-1:0]    lead_len;
   logic [utf8sd_pkg::CpWidth-1:0]     lead_bits;
   logic                               lead_ascii;
   logic [utf8sd_pkg::CountWidth-1:0]  reps;

   assign pending       = (len_ff != utf8sd_pkg::LenIdle);
   assign is_cont       = (text_byte[7:6] == utf8sd_pkg::ContPrefix);
   assign gathered_next = gathered_ff + utf8sd_pkg::GatherWidth'(1);
   assign partial_shift = {partial_ff[utf8sd_pkg::CpWidth-utf8sd_pkg::PayloadBits-1:0],
                           text_byte[utf8sd_pkg::PayloadBits-1:0]};
   assign seq_done      = ((utf8sd_pkg::LenWidth'(gathered_next) + 3'd1) >= len_ff);

   // Classify the byte as a fresh lead.
   always_comb begin
      lead_len   = utf8sd_pkg::LenIdle;
      lead_bits  = '0;
      lead_ascii = 1'b0;
      priority if (text_byte[7] == 1'b0) begin
         lead_ascii = 1'b1;
      end else if (text_byte[7:5] == utf8sd_pkg::Lead2Prefix) begin
         lead_len  = utf8sd_pkg::Len2;
         lead_bits = utf8sd_pkg::CpWidth'(text_byte[4:0]);
      end else if (text_byte[7:4] == utf8sd_pkg::Lead3Prefix) begin
         lead_len  = utf8sd_pkg::Len3;
         lead_bits = utf8sd_pkg::CpWidth'(text_byte[3:0]);
      end else if (text_byte[7:3] == utf8sd_pkg::Lead4Prefix) begin
         lead_len  = utf8sd_pkg::Len4;
         lead_bits = utf8sd_pkg::CpWidth'(text_byte[2:0]);
      end else begin
         lead_len = utf8sd_pkg::LenIdle;
      end
   end

   always_comb begin
      len_in          = len_ff;
      gathered_in     = gathered_ff;
      partial_in      = partial_ff;
      burst.rep_count = '0;
      burst.has_data  = 1'b0;
      burst.data      = utf8sd_pkg::CpWidth'(text_byte);
      reps            = '0;
      if (pending && is_cont) begin
         if (seq_done) begin
            burst.has_data = 1'b1;
            burst.data     = partial_shift;
            len_in         = utf8sd_pkg::LenIdle;
            gathered_in    = '0;
            partial_in     = '0;
         end else if (end_of_text) begin
            burst.rep_count = utf8sd_pkg::CountWidth'(gathered_next) + 3'd1;
            len_in          = utf8sd_pkg::LenIdle;
            gathered_in     = '0;
            partial_in      = '0;
         end else begin
            gathered_in = gathered_next;
            partial_in  = partial_shift;
         end
      end else begin
         // A pending sequence broken by this byte: lead plus gathered bytes.
         if (pending) begin
            reps = utf8sd_pkg::CountWidth'(gathered_ff) + 3'd1;
         end
         gathered_in = '0;
         if (lead_ascii) begin
            burst.has_data = 1'b1;
            len_in         = utf8sd_pkg::LenIdle;
            partial_in     = '0;
         end else if (lead_len == utf8sd_pkg::LenIdle) begin
            // Stray continuation or a byte from F8 up.
            reps       = reps + 3'd1;
            len_in     = utf8sd_pkg::LenIdle;
            partial_in = '0;
         end else if (end_of_text) begin
            // The new lead is flushed at once by the end of the text.
            reps       = reps + 3'd1;
            len_in     = utf8sd_pkg::LenIdle;
            partial_in = '0;
         end else begin
            len_in     = lead_len;
            partial_in = lead_bits;
         end
         burst.rep_count = reps;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff      <= utf8sd_pkg::LenIdle;
         gathered_ff <= '0;
         partial_ff  <= '0;
      end else if (fire) begin
         len_ff      <= len_in;
         gathered_ff <= gathered_in;
         partial_ff  <= partial_in;
      end
   end

   // A pending sequence never holds as many continuations as its length.
   a_gather_below_len: assert property (@(posedge clock) disable iff (reset)
      pending |-> (utf8sd_pkg::LenWidth'(gathered_ff) + 3'd1 < len_ff))
      else $error("gathered count reached sequence length");

endmodule

[rtl/core/utf8sd_burst.sv]
module utf8sd_burst (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             load,
   input  utf8sd_pkg::burst_type            next_burst,
   input  logic [utf8sd_pkg::CpWidth-1:0]   replacement,
   input  logic                             rsp_ready,
   output logic                             rsp_valid,
   output logic [utf8sd_pkg::CpWidth-1:0]   rsp_code_point,
   output logic                             rsp_last_of_run,
   output logic                             free
);

   logic [utf8sd_pkg::CountWidth-1:0] rep_left_ff, rep_left_in;
   logic                              has_data_ff, has_data_in;
   logic [utf8sd_pkg::CpWidth-1:0]    data_ff, data_in;
   logic                              take;

   assign rsp_valid       = (rep_left_ff != '0) || has_data_ff;
   assign rsp_last_of_run = (rep_left_ff == '0) || ((rep_left_ff == 3'd1) && !has_data_ff);
   assign rsp_code_point  = (rep_left_ff != '0) ? replacement : data_ff;
   assign take            = rsp_valid && rsp_ready;
   assign free            = !rsp_valid || (take && rsp_last_of_run);

   always_comb begin
      rep_left_in = rep_left_ff;
      has_data_in = has_data_ff;
      data_in     = data_ff;
      if (load) begin
         rep_left_in = next_burst.rep_count;
         has_data_in = next_burst.has_data;
         data_in     = next_burst.data;
      end else if (take) begin
         if (rep_left_ff != '0) begin
            rep_left_in = rep_left_ff - 3'd1;
         end else begin
            has_data_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rep_left_ff <= '0;
         has_data_ff <= 1'b0;
      end else begin
         rep_left_ff <= rep_left_in;
         has_data_ff <= has_data_in;
      end
      data_ff <= data_in;
   end

   a_burst_bound: assert property (@(posedge clock) disable iff (reset)
      (utf8sd_pkg::CountWidth'(rep_left_ff) + utf8sd_pkg::CountWidth'(has_data_ff)
       <= utf8sd_pkg::MaxResults))
      else $error("burst holds more results than one byte can cause");

   a_load_only_when_free: assert property (@(posedge clock) disable iff (reset)
      load |-> free)
      else $error("burst loaded over undelivered results");

   a_mid_burst_continues: assert property (@(posedge clock) disable iff (reset)
      (take && !rsp_last_of_run) |=> rsp_valid)
      else $error("burst ended before its last beat");

   a_last_beat_drains: assert property (@(posedge clock) disable iff (reset)
      (take && rsp_last_of_run && !load) |=> !rsp_valid)
      else $error("result shown after the last beat of a burst");

endmodule
